/* design/brle_pkg.sv */
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the bit run-length encoder
// Widths of the byte, run length and bit index, and the item and result
// records that travel through the queues.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int BYTE_W    = 8;
  localparam int RUN_LEN_W = 7;
  localparam int BIT_IDX_W = 3;

  localparam logic [BIT_IDX_W-1:0] BIT_FIRST = BIT_IDX_W'(BYTE_W - 1);
  localparam logic [BIT_IDX_W-1:0] BIT_LAST  = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              last_of_item;
  } result_t;

endpackage

/* design/brle_fifo.sv */
// ----------------------------------------------------------------------------
// brle_fifo: small synchronous queue
// Register-based first-in first-out buffer; push and pop may occur in the
// same cycle. DEPTH is a power of two, at least 2.
// ----------------------------------------------------------------------------
module brle_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wr_ptr;
  logic [AW:0]  rd_ptr;
  logic         do_push;
  logic         do_pop;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

/* design/brle_scan.sv */
// ----------------------------------------------------------------------------
// brle_scan: bit scanner and code generator
// Walks one queued byte a bit per cycle while the result queue has room,
// tracks the open run, and stages each code so the final code of a byte can be marked.
// ----------------------------------------------------------------------------
module brle_scan import brle_pkg::*; #(
  parameter int MAX_RUN = 127
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_take,
  output result_t res,
  output logic    res_push,
  input  logic    res_full
);

  localparam logic [RUN_LEN_W-1:0] RUN_MAX = RUN_LEN_W'(MAX_RUN);

  // run state
  logic                 run_value, run_value_next;
  logic [RUN_LEN_W-1:0] run_length, run_length_next;
  logic                 run_open, run_open_next;
  // scan position
  logic [BIT_IDX_W-1:0] bit_idx, bit_idx_next;
  logic                 flush, flush_next;
  // staged code
  logic                 stage_valid;
  logic                 stage_final;
  logic [BYTE_W-1:0]    stage_code;

  logic                 cur_bit;
  logic [RUN_LEN_W-1:0] len_inc;
  logic                 gen;
  logic [BYTE_W-1:0]    gen_code;
  logic                 end_step;
  logic                 push_need;
  logic                 advance;

  assign cur_bit = item.data_byte[bit_idx];
  assign len_inc = run_length + 1'b1;

  // one scan step of the byte at the head of the queue
  always_comb begin
    run_value_next  = run_value;
    run_length_next = run_length;
    run_open_next   = run_open;
    bit_idx_next    = bit_idx;
    flush_next      = flush;
    gen             = 1'b0;
    gen_code        = {run_value, run_length};
    end_step        = 1'b0;
    if (item_valid) begin
      if (flush) begin
        gen             = 1'b1;
        run_open_next   = 1'b0;
        run_length_next = '0;
        flush_next      = 1'b0;
        bit_idx_next    = BIT_FIRST;
        end_step        = 1'b1;
      end else begin
        if (run_open && (cur_bit == run_value)) begin
          if (len_inc >= RUN_MAX) begin
            gen             = 1'b1;
            gen_code        = {run_value, len_inc};
            run_open_next   = 1'b0;
            run_length_next = '0;
          end else begin
            run_length_next = len_inc;
          end
        end else begin
          gen             = run_open;
          run_value_next  = cur_bit;
          run_length_next = RUN_LEN_W'(1);
          run_open_next   = 1'b1;
        end
        if (bit_idx == BIT_LAST) begin
          bit_idx_next = BIT_FIRST;
          if (item.end_of_data && run_open_next) begin
            flush_next = 1'b1;
          end else begin
            end_step = 1'b1;
          end
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
    end
  end

  // release the staged code once the next code or the end of the byte is known
  assign push_need = stage_valid && (stage_final || gen || end_step);
  assign res_push  = push_need && !res_full;
  assign advance   = item_valid && !(push_need && res_full);
  assign item_take = advance && end_step;
  assign res.code_byte    = stage_code;
  assign res.last_of_item = stage_final || (end_step && !gen);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value   <= 1'b0;
      run_length  <= '0;
      run_open    <= 1'b0;
      bit_idx     <= BIT_FIRST;
      flush       <= 1'b0;
      stage_valid <= 1'b0;
      stage_final <= 1'b0;
    end else begin
      if (res_push) begin
        stage_valid <= 1'b0;
        stage_final <= 1'b0;
      end
      if (advance) begin
        run_value  <= run_value_next;
        run_length <= run_length_next;
        run_open   <= run_open_next;
        bit_idx    <= bit_idx_next;
        flush      <= flush_next;
        if (gen) begin
          stage_valid <= 1'b1;
          stage_final <= end_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && gen) begin
      stage_code <= gen_code;
    end
  end

  a_len_below_max: assert property (@(posedge clk) disable iff (rst)
    run_open |-> (run_length < RUN_MAX))
    else $error("open run reached its maximum length without a code");

  a_closed_run_empty: assert property (@(posedge clk) disable iff (rst)
    !run_open |-> (run_length == '0))
    else $error("closed run holds a length");

  a_flush_needs_run: assert property (@(posedge clk) disable iff (rst)
    flush |-> (run_open && item_valid && item.end_of_data))
    else $error("flush step without a pending run at end of data");

  a_final_drains: assert property (@(posedge clk) disable iff (rst)
    (stage_final && !res_full) |-> res_push && res.last_of_item)
    else $error("final code of a byte not released");

  a_stall_holds_pos: assert property (@(posedge clk) disable iff (rst)
    (item_valid && push_need && res_full) |=> $stable(bit_idx) && $stable(run_length))
    else $error("scan advanced while the result queue was full");

endmodule

/* design/bit_run_length_encoder_top.sv */
// ----------------------------------------------------------------------------
// bit_run_length_encoder_top: bit run-length encoder with 7-bit run counts
// Input bytes form one bit stream, most significant bit first; each
// finished run of equal bits leaves as one code byte.
// ----------------------------------------------------------------------------
// Usage: push bytes while full is low; pop code bytes while empty is low.
// Each code carries the run's bit value in bit 7 and its length, 1 to
// MAX_RUN, in bits 6..0; a run that reaches MAX_RUN leaves at once and the
// next bit opens a fresh run. A byte marked end_of_data flushes the pending
// run after its own bits, so the next byte begins a new stream. The code that
// closes the output of a byte has last_of_item set; a byte that finishes no
// run gives no code at all. Throughput is set by the scanner, which handles
// one bit per cycle as long as the result queue has room, plus a flush step
// when the end_of_data flag of a byte finds a pending run. The request queue
// holds up to IN_DEPTH bytes, the one under scan included, and up to
// OUT_DEPTH codes wait behind the scanner, plus one staged code. Each code is
// held back until the next code or the end of its byte shows whether it is
// the last one, and longer while the result queue is full.
// ----------------------------------------------------------------------------
module bit_run_length_encoder_top import brle_pkg::*; #(
  parameter int MAX_RUN   = 127,
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  // request side
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_data,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] code_byte,
  output logic              last_of_item
);

  item_t   in_item;
  item_t   head_item;
  logic    head_empty;
  logic    head_take;
  result_t scan_res;
  logic    scan_push;
  logic    res_full;
  result_t out_res;

  // front: hold incoming requests until the scanner takes them
  assign in_item.data_byte   = data_byte;
  assign in_item.end_of_data = end_of_data;

  brle_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (IN_DEPTH)
  ) u_req_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (head_take),
    .rdata (head_item),
    .empty (head_empty)
  );

  // back: scan one bit per cycle while the result queue has room, and stage the codes
  brle_scan #(
    .MAX_RUN (MAX_RUN)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .item       (head_item),
    .item_valid (!head_empty),
    .item_take  (head_take),
    .res        (scan_res),
    .res_push   (scan_push),
    .res_full   (res_full)
  );

  // result queue: decouple the consumer from the scanner
  brle_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (scan_push),
    .wdata (scan_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign code_byte    = out_res.code_byte;
  assign last_of_item = out_res.last_of_item;

endmodule

/* tb/tb_bit_run_length_encoder_top.sv */
// ----------------------------------------------------------------------------
// tb_bit_run_length_encoder_top: self-checking bench for the bit run-length
// encoder
// Push bytes through the request queue, predict the run codes of every
// accepted request bit by bit, and compare each popped code in order. Both
// sides stall at random, in three phases of different pressure.
// ----------------------------------------------------------------------------
module tb_bit_run_length_encoder_top;
  import brle_pkg::*;

  localparam int MAX_RUN          = 127;
  localparam int RANDOM_PER_PHASE = 135;
  localparam int NUM_PHASES       = 3;
  localparam int STALL_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 40;

  // One queued request plus the bench-side controls that travel with it.
  typedef struct {
    item_t req;
    int    phase;
    bit    drain_first;
  } stim_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              push         = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] data_byte    = '0;
  logic              end_of_data  = 1'b0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [BYTE_W-1:0] code_byte;
  logic              last_of_item;

  stim_t   pending_requests[$];
  result_t expected_codes[$];

  // Stall rates per phase, in percent: receiver slow first, then sender slow,
  // then both running flat out.
  int send_idle_pct [NUM_PHASES] = '{17, 66, 0};
  int recv_idle_pct [NUM_PHASES] = '{66, 17, 0};
  int cur_phase = 0;
  bit hold_next = 1'b0;

  // Encoder state as the bench predicts it.
  logic                 run_bit     = 1'b0;
  logic [RUN_LEN_W-1:0] run_len     = '0;
  logic                 run_pending = 1'b0;

  int errors         = 0;
  int bytes_sent     = 0;
  int eod_bytes      = 0;
  int codes_checked  = 0;
  int full_run_codes = 0;
  int stall_cycles   = 0;

  bit_run_length_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_data  (end_of_data),
    .empty        (empty),
    .pop          (pop),
    .code_byte    (code_byte),
    .last_of_item (last_of_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic result_t run_code(input logic value, input logic [RUN_LEN_W-1:0] len);
    result_t rec;
    rec.code_byte    = {value, len};
    rec.last_of_item = 1'b0;
    return rec;
  endfunction

  // Scan one accepted request MSB first and append the codes it closes.
  function automatic void encode_request(input item_t req);
    result_t fresh[$];
    logic    bit_val;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      bit_val = req.data_byte[i];
      if (run_pending && bit_val == run_bit) begin
        run_len = run_len + 1'b1;
        // a saturated run leaves at once; the next bit opens a fresh one
        if (run_len >= MAX_RUN) begin
          fresh.push_back(run_code(run_bit, run_len));
          run_pending = 1'b0;
          run_len     = '0;
        end
      end else begin
        if (run_pending) begin
          fresh.push_back(run_code(run_bit, run_len));
        end
        run_bit     = bit_val;
        run_len     = RUN_LEN_W'(1);
        run_pending = 1'b1;
      end
    end
    // flush the open run, if any, after the last byte of a stream
    if (req.end_of_data && run_pending) begin
      fresh.push_back(run_code(run_bit, run_len));
      run_pending = 1'b0;
      run_len     = '0;
    end
    if (fresh.size() > 0) begin
      fresh[fresh.size() - 1].last_of_item = 1'b1;
    end
    foreach (fresh[k]) begin
      expected_codes.push_back(fresh[k]);
    end
  endfunction

  function automatic void add_request(input logic [BYTE_W-1:0] value, input logic eod,
                                      input int phase);
    stim_t s;
    s.req.data_byte   = value;
    s.req.end_of_data = eod;
    s.phase           = phase;
    s.drain_first     = hold_next;
    hold_next         = 1'b0;
    pending_requests.push_back(s);
  endfunction

  // Driver: predict on acceptance, then hold, idle or launch the next request.
  always @(posedge clk) begin : drive_requests
    item_t taken;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        taken.data_byte   = data_byte;
        taken.end_of_data = end_of_data;
        encode_request(taken);
        bytes_sent++;
        if (end_of_data) begin
          eod_bytes++;
        end
      end
      if (push && full) begin
        // hold the request until the block takes it
      end else if (pending_requests.size() == 0) begin
        push <= 1'b0;
      end else if (pending_requests[0].drain_first && expected_codes.size() != 0) begin
        // pause until every predicted code has been popped
        push <= 1'b0;
      end else if ($urandom_range(0, 99) < send_idle_pct[pending_requests[0].phase]) begin
        push <= 1'b0;
      end else begin
        cur_phase   = pending_requests[0].phase;
        data_byte   <= pending_requests[0].req.data_byte;
        end_of_data <= pending_requests[0].req.end_of_data;
        push        <= 1'b1;
        void'(pending_requests.pop_front());
      end
    end
  end

  // Monitor: check each popped code against the oldest prediction.
  always @(posedge clk) begin : check_codes
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected code: code_byte %02h last_of_item %0b", code_byte, last_of_item);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          if (code_byte !== want.code_byte) begin
            $error("code_byte: expected %02h, got %02h", want.code_byte, code_byte);
            errors++;
          end
          if (last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0b, got %0b", want.last_of_item, last_of_item);
            errors++;
          end
          codes_checked++;
          if (code_byte[RUN_LEN_W-1:0] == MAX_RUN) begin
            full_run_codes++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
    end
  end

  // Count cycles in which neither side moves anything.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int                made;
    int                kind;
    int                burst;
    logic [BYTE_W-1:0] fill;

    // Directed: a flushed run right out of reset, alternating bits (a code
    // per transition), nibble edges, a flush after a run of ones, a byte
    // that closes nothing.
    add_request(8'h00, 1'b1, 0);
    add_request(8'h55, 1'b0, 0);
    add_request(8'hAA, 1'b0, 0);
    add_request(8'h0F, 1'b0, 0);
    add_request(8'hF0, 1'b1, 0);
    add_request(8'hFF, 1'b0, 0);
    add_request(8'hFF, 1'b0, 0);
    add_request(8'h00, 1'b1, 0);
    // A run of ones that saturates on the very last bit of a byte marked
    // end of data, so the flush finds no open run.
    add_request(8'h7F, 1'b0, 0);
    for (int n = 0; n < 15; n++) begin
      add_request(8'hFF, n == 14, 0);
    end

    // Random: mostly run-shaped traffic so that saturation, long streams
    // and dense transitions come up often, with plain noise in between.
    for (int p = 0; p < NUM_PHASES; p++) begin
      made      = 0;
      hold_next = 1'b1;
      while (made < RANDOM_PER_PHASE) begin
        if ($urandom_range(0, 59) == 0) begin
          hold_next = 1'b1;
        end
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3: begin
            add_request(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, p);
            made++;
          end
          4, 5: begin
            // long run that mostly passes the saturation point, then a random tail
            fill  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            burst = $urandom_range(14, 34);
            for (int n = 0; n < burst; n++) begin
              add_request(fill, 1'b0, p);
            end
            add_request(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), p);
            made += burst + 1;
          end
          6: begin
            // alternating bits: the most codes a byte can yield
            burst = $urandom_range(1, 4);
            for (int n = 0; n < burst; n++) begin
              add_request($urandom_range(0, 1) ? 8'h55 : 8'hAA, n == burst - 1 &&
                          $urandom_range(0, 1) != 0, p);
            end
            made += burst;
          end
          7: begin
            // saturate exactly at a byte boundary of an ending stream
            fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            add_request(~fill ^ 8'h7F, 1'b0, p);
            for (int n = 0; n < 15; n++) begin
              add_request(fill, n == 14, p);
            end
            made += 16;
          end
          8: begin
            add_request(BYTE_W'($urandom_range(0, 255)), 1'b1, p);
            made++;
          end
          default: begin
            // one lone bit against a flat background
            fill = 8'h01 << $urandom_range(0, 7);
            add_request($urandom_range(0, 1) ? fill : ~fill, 1'b0, p);
            made++;
          end
        endcase
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken, every prediction popped, then watch a while
    // for stray codes.
    wait (pending_requests.size() == 0 && push == 1'b0);
    wait (expected_codes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Encoded %0d bytes (%0d ending a stream) into %0d checked codes,",
             bytes_sent, eod_bytes, codes_checked);
    $display("%0d of them saturated runs of %0d bits.", full_run_codes, MAX_RUN);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/brle_pkg.sv
design/brle_fifo.sv
design/brle_scan.sv
design/bit_run_length_encoder_top.sv
tb/tb_bit_run_length_encoder_top.sv
